FILE: rtl/mws_pkg.sv
package mws_pkg;

	// Field widths of one input and one result word
	localparam int KindW  = 2;
	localparam int ChanW  = 2;
	localparam int ModeW  = 2;
	localparam int ValW   = 32;
	localparam int MaskW  = 4;

	// Default number of channels
	localparam int ChannelsDef = 4;

	// Word kinds
	localparam logic [KindW-1:0] KIND_TICK  = 2'd0;
	localparam logic [KindW-1:0] KIND_START = 2'd1;
	localparam logic [KindW-1:0] KIND_STOP  = 2'd2;

	// Channel modes
	localparam logic [ModeW-1:0] MODE_MANUAL = 2'd0;
	localparam logic [ModeW-1:0] MODE_TIMED  = 2'd1;
	localparam logic [ModeW-1:0] MODE_SMART  = 2'd2;

	localparam logic [ValW-1:0] ValMax = '1;

	// Per-lane event strobes, already qualified by the pipeline advance
	typedef struct packed {
		logic tick;
		logic start;
		logic stop;
	} lane_ctl_t;

endpackage

FILE: rtl/mws_if.sv
// Command channel: one word per tick, start or stop
interface mws_in_if;
	logic                        valid;
	logic                        ready;
	logic [mws_pkg::KindW-1:0]   kind;
	logic [mws_pkg::ChanW-1:0]   chan;
	logic [mws_pkg::ModeW-1:0]   mode;
	logic [mws_pkg::ValW-1:0]    on_amount;
	logic [mws_pkg::ValW-1:0]    period;
	logic [mws_pkg::ValW-1:0]    water_total;

	modport source (output valid, kind, chan, mode, on_amount, period, water_total,
		input ready);
	modport sink (input valid, kind, chan, mode, on_amount, period, water_total,
		output ready);
endinterface

// Status channel: motor and active masks after each command word
interface mws_out_if;
	logic                        valid;
	logic                        ready;
	logic [mws_pkg::MaskW-1:0]   motor_mask;
	logic [mws_pkg::MaskW-1:0]   active_mask;

	modport source (output valid, motor_mask, active_mask, input ready);
	modport sink (input valid, motor_mask, active_mask, output ready);
endinterface

FILE: rtl/mws_lane.sv
module mws_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mws_pkg::lane_ctl_t          ctl,
	input  logic [mws_pkg::ModeW-1:0]   mode,
	input  logic [mws_pkg::ValW-1:0]    on_amount,
	input  logic [mws_pkg::ValW-1:0]    period,
	input  logic [mws_pkg::ValW-1:0]    water,
	input  logic [mws_pkg::ValW-1:0]    last_water,
	output logic                        nxt_active,
	output logic                        nxt_motor
);
	import mws_pkg::*;

	logic              active_q, phase_q;
	logic [ModeW-1:0]  mode_q;
	logic [ValW-1:0]   elapsed_q, base_q, on_q, per_q, off_q;

	logic              nxt_phase;
	logic [ModeW-1:0]  nxt_mode;
	logic [ValW-1:0]   nxt_elapsed, nxt_base, nxt_on, nxt_per, nxt_off;
	logic [ValW-1:0]   el_inc, got;

	// Saturating elapsed count and water delivered since cycle start
	assign el_inc = (elapsed_q == ValMax) ? elapsed_q : elapsed_q + 1'b1;
	assign got    = water - base_q;

	// Next channel state
	always_comb begin
		nxt_active  = active_q;
		nxt_phase   = phase_q;
		nxt_mode    = mode_q;
		nxt_elapsed = elapsed_q;
		nxt_base    = base_q;
		nxt_on      = on_q;
		nxt_per     = per_q;
		nxt_off     = off_q;
		if (ctl.stop) begin
			nxt_active = 1'b0;
			nxt_phase  = 1'b0;
		end else if (ctl.start) begin
			nxt_active  = 1'b1;
			nxt_mode    = mode;
			nxt_on      = on_amount;
			nxt_per     = period;
			// off time of a timed cycle, clamped at zero
			nxt_off     = (period > on_amount) ? period - on_amount : '0;
			nxt_elapsed = '0;
			nxt_base    = last_water;
			nxt_phase   = (mode != MODE_TIMED);
		end else if (ctl.tick && active_q) begin
			nxt_elapsed = el_inc;
			if (mode_q == MODE_TIMED) begin
				if (!phase_q) begin
					if (el_inc >= off_q) begin
						nxt_phase   = 1'b1;
						nxt_elapsed = '0;
					end
				end else if (el_inc >= on_q) begin
					nxt_phase   = 1'b0;
					nxt_elapsed = '0;
				end
			end else if (mode_q == MODE_SMART) begin
				if (phase_q) begin
					if (got >= on_q) nxt_phase = 1'b0;
				end else if (el_inc >= per_q) begin
					nxt_base    = water;
					nxt_elapsed = '0;
					nxt_phase   = 1'b1;
				end
			end
		end
	end

	assign nxt_motor = nxt_active && (nxt_mode == MODE_MANUAL || nxt_phase);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= 1'b0;
			mode_q   <= MODE_MANUAL;
		end else begin
			active_q <= nxt_active;
			phase_q  <= nxt_phase;
			mode_q   <= nxt_mode;
		end
	end

	// Timing and amount registers, only read while active
	always_ff @(posedge clk) begin
		elapsed_q <= nxt_elapsed;
		base_q    <= nxt_base;
		on_q      <= nxt_on;
		per_q     <= nxt_per;
		off_q     <= nxt_off;
	end

endmodule

FILE: rtl/multichannel_watering_sequencer.sv
// Pump sequencer for up to CHANNELS watering channels.
// item (sink): one word per event. kind tick stands for one millisecond and
//   carries the cumulative water count; kind start loads mode, on amount and
//   period into channel chan and begins its event; kind stop ends the events
//   on all channels. Starts with mode 3 or a channel beyond CHANNELS do nothing.
// result (source): one word per item, the motor and active masks of channels
//   0 to 3 after that item has been applied.
// Path: a word accepted into the input register has its result loaded into the
//   result register when the pipeline advances.
// Throughput: one word per cycle while the result is taken; every channel lane
//   updates in parallel from the input register, with one 32-bit subtract and compare
//   per lane on the critical path.
// Reset: all channels stopped, last water count zero, both pipeline stages
//   empty; the mask registers are not reset.
// Stall: while the result is not taken the result register holds, the input
//   register fills and then item.ready drops; nothing is lost or repeated.
module multichannel_watering_sequencer #(
	parameter int CHANNELS = mws_pkg::ChannelsDef
) (
	input logic     clk,
	input logic     arst_n,
	mws_in_if.sink  item,
	mws_out_if.source result
);
	import mws_pkg::*;

	logic              vld_s1;
	logic [KindW-1:0]  kind_s1;
	logic [ChanW-1:0]  chan_s1;
	logic [ModeW-1:0]  mode_s1;
	logic [ValW-1:0]   on_s1, per_s1, water_s1;

	logic              res_vld_q;
	logic [MaskW-1:0]  motor_q, active_q;
	logic [ValW-1:0]   last_water_q;

	logic              adv, proc, start_ok;
	logic [CHANNELS-1:0] lane_active, lane_motor;
	logic [MaskW-1:0]  nxt_motor_mask, nxt_active_mask;

	// Pipeline flow; modes above smart carry no goal
	assign adv        = !res_vld_q || result.ready;
	assign item.ready = !vld_s1 || adv;
	assign proc       = vld_s1 && adv;
	assign start_ok   = proc && kind_s1 == KIND_START && mode_s1 <= MODE_SMART;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1  <= item.kind;
			chan_s1  <= item.chan;
			mode_s1  <= item.mode;
			on_s1    <= item.on_amount;
			per_s1   <= item.period;
			water_s1 <= item.water_total;
		end
	end

	// Water count of the latest tick, the base for new starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_water_q <= '0;
		end else if (proc && kind_s1 == KIND_TICK) begin
			last_water_q <= water_s1;
		end
	end

	// One lane per channel
	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		lane_ctl_t ctl;
		assign ctl.tick  = proc && kind_s1 == KIND_TICK;
		assign ctl.stop  = proc && kind_s1 == KIND_STOP;
		assign ctl.start = start_ok && (32'(chan_s1) == 32'(i));

		mws_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.mode       (mode_s1),
			.on_amount  (on_s1),
			.period     (per_s1),
			.water      (water_s1),
			.last_water (last_water_q),
			.nxt_active (lane_active[i]),
			.nxt_motor  (lane_motor[i])
		);
	end

	// Masks show channels 0 to 3; missing channels read zero
	for (genvar m = 0; m < MaskW; m++) begin : g_mask
		if (m < CHANNELS) begin : g_on
			assign nxt_motor_mask[m]  = lane_motor[m];
			assign nxt_active_mask[m] = lane_active[m];
		end else begin : g_off
			assign nxt_motor_mask[m]  = 1'b0;
			assign nxt_active_mask[m] = 1'b0;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			motor_q  <= nxt_motor_mask;
			active_q <= nxt_active_mask;
		end
	end

	assign result.valid       = res_vld_q;
	assign result.motor_mask  = motor_q;
	assign result.active_mask = active_q;

	// A motor only runs on an active channel
	a_motor_in_active: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.motor_mask & ~result.active_mask) == '0)
		else $error("motor on for an inactive channel");

	// A stop word leaves every channel inactive in its result
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && kind_s1 == KIND_STOP |=> res_vld_q && active_q == '0)
		else $error("channel still active after stop");

	// A valid start on a shown channel marks that channel active
	a_start_sets: assert property (@(posedge clk) disable iff (!arst_n)
		start_ok && 32'(chan_s1) < CHANNELS |=> active_q[$past(chan_s1)])
		else $error("started channel not active");

	// Input stalls only when both stages are full and the result is held
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> vld_s1 && res_vld_q && !result.ready)
		else $error("input stalled without a full pipeline");

endmodule

FILE: tb/testbench.sv
module testbench;
	import mws_pkg::*;

	localparam int NCH = ChannelsDef;
	localparam logic [KindW-1:0] KIND_NONE   = 2'd3;
	localparam logic [ModeW-1:0] MODE_NOGOAL = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	// two register stages in the block, plus margin
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [ChanW-1:0] chan;
		logic [ModeW-1:0] mode;
		logic [ValW-1:0]  on_amount;
		logic [ValW-1:0]  period;
		logic [ValW-1:0]  water;
	} word_t;

	typedef struct packed {
		logic [MaskW-1:0] motor;
		logic [MaskW-1:0] active;
	} masks_t;

	logic clk;
	logic arst_n;

	mws_in_if  cmd_bus ();
	mws_out_if status_bus ();

	multichannel_watering_sequencer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (cmd_bus),
		.result (status_bus)
	);

	// pump sequencer state as the testbench sees it
	logic            run_q    [NCH] = '{default: 1'b0};
	logic [ModeW-1:0] mode_q  [NCH] = '{default: '0};
	logic            pump_on  [NCH] = '{default: 1'b0};
	logic [ValW-1:0] ms_q     [NCH] = '{default: '0};
	logic [ValW-1:0] base_q   [NCH] = '{default: '0};
	logic [ValW-1:0] amount_q [NCH] = '{default: '0};
	logic [ValW-1:0] cycle_q  [NCH] = '{default: '0};
	logic [ValW-1:0] water_seen = '0;

	masks_t masks_due [$];

	int errors = 0;
	int cycles = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_left = 0;
	logic [ValW-1:0] water_now = '0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("multichannel_watering_sequencer regression: fail");
			$finish;
		end
	end

	// apply one word to the local state and queue the masks it leaves
	task automatic predict_masks(input word_t w);
		logic [ValW-1:0] off_ms;
		logic [ValW-1:0] got;
		masks_t m;
		case (w.kind)
		KIND_TICK: begin
			water_seen = w.water;
			for (int c = 0; c < NCH; c++) begin
				if (run_q[c]) begin
					if (ms_q[c] != ValMax)
						ms_q[c] = ms_q[c] + 1;
					off_ms = (cycle_q[c] > amount_q[c]) ? cycle_q[c] - amount_q[c] : '0;
					got = water_seen - base_q[c];
					if (mode_q[c] == MODE_TIMED) begin
						if (!pump_on[c]) begin
							if (ms_q[c] >= off_ms) begin
								pump_on[c] = 1'b1;
								ms_q[c] = '0;
							end
						end else if (ms_q[c] >= amount_q[c]) begin
							pump_on[c] = 1'b0;
							ms_q[c] = '0;
						end
					end else if (mode_q[c] == MODE_SMART) begin
						// smart off keeps elapsed running from cycle start
						if (pump_on[c]) begin
							if (got >= amount_q[c])
								pump_on[c] = 1'b0;
						end else if (ms_q[c] >= cycle_q[c]) begin
							base_q[c] = water_seen;
							ms_q[c] = '0;
							pump_on[c] = 1'b1;
						end
					end
				end
			end
		end
		KIND_START: begin
			if (w.mode != MODE_NOGOAL && int'(w.chan) < NCH) begin
				mode_q[w.chan]   = w.mode;
				amount_q[w.chan] = w.on_amount;
				cycle_q[w.chan]  = w.period;
				ms_q[w.chan]     = '0;
				base_q[w.chan]   = water_seen;
				pump_on[w.chan]  = (w.mode != MODE_TIMED);
				run_q[w.chan]    = 1'b1;
			end
		end
		KIND_STOP: begin
			for (int c = 0; c < NCH; c++) begin
				run_q[c] = 1'b0;
				pump_on[c] = 1'b0;
			end
		end
		default: ;
		endcase
		m = '0;
		for (int c = 0; c < NCH && c < MaskW; c++) begin
			if (run_q[c]) begin
				m.active[c] = 1'b1;
				if (mode_q[c] == MODE_MANUAL || pump_on[c])
					m.motor[c] = 1'b1;
			end
		end
		masks_due.push_back(m);
	endtask

	// word builders; unused fields carry noise
	function automatic word_t tick_word(input logic [ValW-1:0] water);
		word_t w;
		w.kind = KIND_TICK;
		w.chan = ChanW'($urandom);
		w.mode = ModeW'($urandom);
		w.on_amount = $urandom;
		w.period = $urandom;
		w.water = water;
		return w;
	endfunction

	function automatic word_t start_word(input logic [ChanW-1:0] chan,
		input logic [ModeW-1:0] mode, input logic [ValW-1:0] on_amount,
		input logic [ValW-1:0] period);
		word_t w;
		w.kind = KIND_START;
		w.chan = chan;
		w.mode = mode;
		w.on_amount = on_amount;
		w.period = period;
		w.water = $urandom;
		return w;
	endfunction

	function automatic word_t other_word(input logic [KindW-1:0] kind);
		word_t w;
		w.kind = kind;
		w.chan = ChanW'($urandom);
		w.mode = ModeW'($urandom);
		w.on_amount = $urandom;
		w.period = $urandom;
		w.water = $urandom;
		return w;
	endfunction

	// offer one word, with random gaps, and wait for it to be taken
	task automatic send_word(input word_t w);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid       <= 1'b1;
		cmd_bus.kind        <= w.kind;
		cmd_bus.chan        <= w.chan;
		cmd_bus.mode        <= w.mode;
		cmd_bus.on_amount   <= w.on_amount;
		cmd_bus.period      <= w.period;
		cmd_bus.water_total <= w.water;
		do
			@(posedge clk);
		while (!cmd_bus.ready);
		predict_masks(w);
	endtask

	// stop offering and wait until every status word is back
	task automatic wait_results_done();
		@(negedge clk);
		cmd_bus.valid <= 1'b0;
		while (masks_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly ticks with a slowly rising water count, small programs
	task automatic send_random_word();
		int r;
		logic [ChanW-1:0] ch;
		logic [ModeW-1:0] md;
		logic [ValW-1:0] amt;
		logic [ValW-1:0] per;
		r = $urandom_range(99);
		if (r < 68) begin
			if ($urandom_range(39) == 0)
				water_now = ValMax - $urandom_range(30);
			else if ($urandom_range(19) == 0)
				water_now = $urandom;
			else
				water_now = water_now + $urandom_range(20);
			send_word(tick_word(water_now));
		end else if (r < 88) begin
			ch = ChanW'($urandom_range(NCH - 1));
			md = ($urandom_range(9) == 0) ? MODE_NOGOAL : ModeW'($urandom_range(MODE_SMART));
			if ($urandom_range(7) == 0)
				amt = $urandom;
			else
				amt = (md == MODE_SMART) ? $urandom_range(60) : $urandom_range(8);
			per = ($urandom_range(7) == 0) ? $urandom : $urandom_range(15);
			send_word(start_word(ch, md, amt, per));
		end else if (r < 95) begin
			send_word(other_word(KIND_STOP));
		end else begin
			send_word(other_word(KIND_NONE));
		end
	endtask

	// status receiver: random stalls, or a long hold-off when asked
	initial begin
		status_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				status_bus.ready <= 1'b0;
			end else begin
				status_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// compare each status word with the oldest prediction
	always @(posedge clk) begin
		masks_t exp_m;
		if (arst_n && status_bus.valid && status_bus.ready) begin
			if (masks_due.size() == 0) begin
				errors++;
				$display("%0t unexpected status word motor %h active %h", $time,
					status_bus.motor_mask, status_bus.active_mask);
			end else begin
				exp_m = masks_due.pop_front();
				if (status_bus.motor_mask !== exp_m.motor) begin
					errors++;
					$display("%0t motor_mask expected %h got %h", $time,
						exp_m.motor, status_bus.motor_mask);
				end
				if (status_bus.active_mask !== exp_m.active) begin
					errors++;
					$display("%0t active_mask expected %h got %h", $time,
						exp_m.active, status_bus.active_mask);
				end
			end
		end
	end

	// corner cases: every mode, zero and full amounts, water wrap, restart
	task automatic test_directed();
		src_idle_pct = 20;
		snk_idle_pct = 50;
		send_word(tick_word(32'd100));
		send_word(start_word(2'd0, MODE_MANUAL, $urandom, $urandom));
		send_word(start_word(2'd1, MODE_TIMED, 32'd2, 32'd5));
		send_word(start_word(2'd2, MODE_SMART, 32'd30, 32'd4));
		// on time beyond period: off phase is zero long
		send_word(start_word(2'd3, MODE_TIMED, ValMax, '0));
		send_word(tick_word(32'd110));
		send_word(tick_word(32'd125));
		send_word(tick_word(32'd140));
		send_word(tick_word(ValMax - 5));
		// water count wraps through zero
		send_word(tick_word(32'd20));
		send_word(start_word(2'd3, MODE_NOGOAL, 32'd1, 32'd1));
		send_word(other_word(KIND_NONE));
		// restart a running channel with zero on time and period
		send_word(start_word(2'd1, MODE_TIMED, '0, '0));
		send_word(tick_word(32'd21));
		send_word(tick_word(32'd22));
		send_word(start_word(2'd2, MODE_SMART, '0, '0));
		send_word(tick_word(32'd22));
		send_word(tick_word(32'd23));
		send_word(start_word(2'd3, MODE_SMART, ValMax, ValMax));
		send_word(other_word(KIND_STOP));
		send_word(tick_word(32'd30));
		send_word(start_word(2'd0, MODE_TIMED, 32'd1, ValMax));
		send_word(tick_word(32'd31));
		send_word(other_word(KIND_STOP));
		wait_results_done();
	endtask

	task automatic test_random(input int n, input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		repeat (n) send_random_word();
		wait_results_done();
	endtask

	// receiver stalls long while the sender keeps offering
	task automatic test_backpressure();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_left = 60;
		repeat (40) send_random_word();
		wait_results_done();
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.kind = KIND_TICK;
		cmd_bus.chan = '0;
		cmd_bus.mode = MODE_MANUAL;
		cmd_bus.on_amount = '0;
		cmd_bus.period = '0;
		cmd_bus.water_total = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(650, 35, 80);
		test_random(650, 80, 35);
		test_backpressure();
		test_random(650, 0, 0);

		if (errors == 0)
			$display("multichannel_watering_sequencer regression: pass");
		else
			$display("multichannel_watering_sequencer regression: fail");
		$finish;
	end

endmodule
